// ===== design/lwwp_pkg.sv =====
// Shared types and constants for the LCD window write packer.
// Used by the front, queue, back and top-level files; no dependencies.
package lwwp_pkg;

    localparam logic [8:0] DATA_FLAG = 9'h100;

    // configuration register indexes
    localparam logic [2:0] REG_PANEL_WIDTH   = 3'd0;
    localparam logic [2:0] REG_PANEL_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_VALIDATE      = 3'd2;
    localparam logic [2:0] REG_OP_COLUMN_SET = 3'd3;
    localparam logic [2:0] REG_OP_PAGE_SET   = 3'd4;
    localparam logic [2:0] REG_OP_MEM_WRITE  = 3'd5;
    localparam logic [2:0] REG_OP_NO_OP      = 3'd6;

    localparam logic [7:0] RST_PANEL_WIDTH   = 8'd132;
    localparam logic [7:0] RST_PANEL_HEIGHT  = 8'd132;
    localparam logic [7:0] RST_OP_COLUMN_SET = 8'd21;
    localparam logic [7:0] RST_OP_PAGE_SET   = 8'd117;
    localparam logic [7:0] RST_OP_MEM_WRITE  = 8'd92;
    localparam logic [7:0] RST_OP_NO_OP      = 8'd37;

    // last word index of each job kind
    localparam logic [3:0] LAST_STEP_HDR   = 4'd6;
    localparam logic [3:0] LAST_STEP_PIXEL = 4'd9;
    localparam logic [3:0] LAST_STEP_TUPLE = 4'd2;
    localparam logic [3:0] TAIL_START      = 4'd7;

    typedef enum logic [1:0] {
        JOB_HDR,
        JOB_HDR_SINGLE,
        JOB_PAIR,
        JOB_SINGLE
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  x_lo;
        logic [7:0]  x_hi;
        logic [7:0]  y_lo;
        logic [7:0]  y_hi;
        logic [11:0] c1;
        logic [11:0] c2;
    } job_t;

    typedef struct packed {
        logic [7:0] panel_width;
        logic [7:0] panel_height;
        logic       validate;
    } front_cfg_t;

    typedef struct packed {
        logic [7:0] column_set;
        logic [7:0] page_set;
        logic [7:0] mem_write;
        logic [7:0] no_op;
    } op_cfg_t;

endpackage

// ===== design/lcd_window_write_packer.sv =====
// Top level of the LCD window write packer: configuration registers,
// front end, job queue and word back end. Depends on lwwp_pkg and lwwp_* modules.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | input     | in_valid / in_stall  | cmd, x_start, y_start, width_req,
//          |           |                      | height_req, color
//  out     | output    | out_valid / out_stall| spi_word, last_word
//  cfg     | input     | cfg_we               | cfg_addr, cfg_wdata
//
// One request is taken per cycle while the job queue has room; each becomes up to
// ten words (draw pixel), seven for a window header, three per pixel tuple.
// Words leave at one per cycle while out_stall is low, set by the back end's
// single word sequencer; the queue takes new requests while earlier words go out.
// Reset clears the window state, the queue and loads the default configuration.
// in_stall rises only when the queue is full; out_stall holds the output word.
module lcd_window_write_packer
    import lwwp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [7:0]  x_start,
    input  logic [7:0]  y_start,
    input  logic [7:0]  width_req,
    input  logic [7:0]  height_req,
    input  logic [11:0] color,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [8:0]  spi_word,
    output logic        last_word
);

    front_cfg_t fcfg_reg;
    op_cfg_t    ops_reg;

    logic accept;
    logic push;
    job_t push_job;
    logic pop;
    job_t head;
    logic q_not_empty;
    logic q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcfg_reg.panel_width   <= RST_PANEL_WIDTH;
            fcfg_reg.panel_height  <= RST_PANEL_HEIGHT;
            fcfg_reg.validate      <= 1'b1;
            ops_reg.column_set     <= RST_OP_COLUMN_SET;
            ops_reg.page_set       <= RST_OP_PAGE_SET;
            ops_reg.mem_write      <= RST_OP_MEM_WRITE;
            ops_reg.no_op          <= RST_OP_NO_OP;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PANEL_WIDTH:   fcfg_reg.panel_width   <= cfg_wdata;
                REG_PANEL_HEIGHT:  fcfg_reg.panel_height  <= cfg_wdata;
                REG_VALIDATE:      fcfg_reg.validate      <= cfg_wdata[0];
                REG_OP_COLUMN_SET: ops_reg.column_set     <= cfg_wdata;
                REG_OP_PAGE_SET:   ops_reg.page_set       <= cfg_wdata;
                REG_OP_MEM_WRITE:  ops_reg.mem_write      <= cfg_wdata;
                REG_OP_NO_OP:      ops_reg.no_op          <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    lwwp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (fcfg_reg),
        .accept     (accept),
        .cmd        (cmd),
        .x_start    (x_start),
        .y_start    (y_start),
        .width_req  (width_req),
        .height_req (height_req),
        .color      (color),
        .push       (push),
        .push_job   (push_job)
    );

    lwwp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head      (head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    lwwp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ops        (ops_reg),
        .head       (head),
        .head_valid (q_not_empty),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .spi_word   (spi_word),
        .last_word  (last_word)
    );

endmodule

// ===== design/lwwp_front.sv =====
// Front end: validates and clips requests, tracks the open window and
// turns each request into at most one job. Depends on lwwp_pkg.
module lwwp_front
    import lwwp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  front_cfg_t  cfg,
    input  logic        accept,
    input  logic [2:0]  cmd,
    input  logic [7:0]  x_start,
    input  logic [7:0]  y_start,
    input  logic [7:0]  width_req,
    input  logic [7:0]  height_req,
    input  logic [11:0] color,
    output logic        push,
    output job_t        push_job
);

    localparam logic [2:0] CMD_DRAW       = 3'd0;
    localparam logic [2:0] CMD_BLIT_OPEN  = 3'd1;
    localparam logic [2:0] CMD_BLIT_PIXEL = 3'd2;
    localparam logic [2:0] CMD_FILL_OPEN  = 3'd3;
    localparam logic [2:0] CMD_FILL_STEP  = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_BLIT,
        MODE_FILL
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [15:0] units_reg, units_next;
    logic [11:0] held_px_reg, held_px_next;
    logic        held_v_reg, held_v_next;
    logic [11:0] fill_reg, fill_next;

    logic        offscreen;
    logic        is_blit;
    logic [8:0]  x_sum, y_sum;
    logic        x_over, y_over;
    logic        win_reject;
    logic [7:0]  cx_eff, cy_eff;
    logic [7:0]  x_end, y_end;
    logic [15:0] prod;
    logic [15:0] fill_units;
    logic [15:0] units_dec;

    assign offscreen = (x_start >= cfg.panel_width) || (y_start >= cfg.panel_height);
    assign is_blit   = (cmd == CMD_BLIT_OPEN);
    assign x_sum     = {1'b0, x_start} + {1'b0, width_req};
    assign y_sum     = {1'b0, y_start} + {1'b0, height_req};
    assign x_over    = x_sum > {1'b0, cfg.panel_width};
    assign y_over    = y_sum > {1'b0, cfg.panel_height};
    assign win_reject = cfg.validate &&
                        ((width_req == 8'd0) || (height_req == 8'd0) || offscreen ||
                         (is_blit && x_over));
    // clip fill width and any height to the screen edge
    assign cx_eff = (cfg.validate && !is_blit && x_over) ?
                    (cfg.panel_width - x_start) : width_req;
    assign cy_eff = (cfg.validate && y_over) ? (cfg.panel_height - y_start) : height_req;
    assign x_end  = x_start + cx_eff - 8'd1;
    assign y_end  = y_start + cy_eff - 8'd1;
    assign prod   = {8'd0, cx_eff} * {8'd0, cy_eff};
    assign fill_units = 16'(({1'b0, prod} + 17'd1) >> 1);
    assign units_dec  = units_reg - 16'd1;

    always_comb
    begin
        mode_next    = mode_reg;
        units_next   = units_reg;
        held_px_next = held_px_reg;
        held_v_next  = held_v_reg;
        fill_next    = fill_reg;
        push         = 1'b0;
        push_job     = '{kind: JOB_HDR, x_lo: x_start, x_hi: x_end, y_lo: y_start,
                         y_hi: y_end, c1: color, c2: color};
        if (accept)
        begin
            case (cmd)
                CMD_DRAW:
                begin
                    if (!(cfg.validate && offscreen))
                    begin
                        mode_next     = MODE_IDLE;
                        units_next    = 16'd0;
                        held_v_next   = 1'b0;
                        push          = 1'b1;
                        push_job.kind = JOB_HDR_SINGLE;
                        push_job.x_hi = x_start;
                        push_job.y_hi = y_start;
                    end
                end
                CMD_BLIT_OPEN, CMD_FILL_OPEN:
                begin
                    if (!win_reject)
                    begin
                        held_v_next = 1'b0;
                        push        = 1'b1;
                        if (is_blit)
                        begin
                            units_next = prod;
                            mode_next  = (prod != 16'd0) ? MODE_BLIT : MODE_IDLE;
                        end
                        else
                        begin
                            units_next = fill_units;
                            fill_next  = color;
                            mode_next  = (fill_units != 16'd0) ? MODE_FILL : MODE_IDLE;
                        end
                    end
                end
                CMD_BLIT_PIXEL:
                begin
                    if (mode_reg == MODE_BLIT && units_reg != 16'd0)
                    begin
                        units_next = units_dec;
                        if (held_v_reg)
                        begin
                            push          = 1'b1;
                            push_job.kind = JOB_PAIR;
                            push_job.c1   = held_px_reg;
                            held_v_next   = 1'b0;
                        end
                        else if (units_dec == 16'd0)
                        begin
                            push          = 1'b1;
                            push_job.kind = JOB_SINGLE;
                        end
                        else
                        begin
                            // hold first pixel of the pair
                            held_px_next = color;
                            held_v_next  = 1'b1;
                        end
                        if (units_dec == 16'd0)
                        begin
                            mode_next   = MODE_IDLE;
                            held_v_next = 1'b0;
                        end
                    end
                end
                CMD_FILL_STEP:
                begin
                    if (mode_reg == MODE_FILL && units_reg != 16'd0)
                    begin
                        units_next    = units_dec;
                        push          = 1'b1;
                        push_job.kind = JOB_PAIR;
                        push_job.c1   = fill_reg;
                        push_job.c2   = fill_reg;
                        if (units_dec == 16'd0)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            units_reg   <= 16'd0;
            held_px_reg <= 12'd0;
            held_v_reg  <= 1'b0;
            fill_reg    <= 12'd0;
        end
        else
        begin
            mode_reg    <= mode_next;
            units_reg   <= units_next;
            held_px_reg <= held_px_next;
            held_v_reg  <= held_v_next;
            fill_reg    <= fill_next;
        end
    end

    a_open_owes_units: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_IDLE) |-> (units_reg != 16'd0))
        else $error("window open with no units owed");

    a_held_in_blit: assert property (@(posedge clk) disable iff (!rst_n)
        held_v_reg |-> (mode_reg == MODE_BLIT))
        else $error("held pixel outside a blit window");

endmodule

// ===== design/lwwp_queue.sv =====
// Short job queue between front and back ends.
// Depends on lwwp_pkg for the job type.
module lwwp_queue
    import lwwp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic not_empty,
    output logic full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("job popped from empty queue");

endmodule

// ===== design/lwwp_back.sv =====
// Back end: expands the head job into serial words, one per cycle unless out_stall
// holds the output, through a registered output stage. Depends on lwwp_pkg.
module lwwp_back
    import lwwp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  op_cfg_t    ops,
    input  job_t       head,
    input  logic       head_valid,
    output logic       pop,
    input  logic       out_stall,
    output logic       out_valid,
    output logic [8:0] spi_word,
    output logic       last_word
);

    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic [8:0] word_reg;
    logic       last_reg;

    logic       load;
    logic [3:0] last_step;
    logic       at_end;
    logic       in_header;
    logic [1:0] tail_idx;
    logic       is_pair;
    logic [8:0] word;
    logic       word_last;

    always_comb
    begin
        case (head.kind)
            JOB_HDR:        last_step = LAST_STEP_HDR;
            JOB_HDR_SINGLE: last_step = LAST_STEP_PIXEL;
            default:        last_step = LAST_STEP_TUPLE;
        endcase
    end

    assign at_end    = (step_reg == last_step);
    assign in_header = ((head.kind == JOB_HDR) || (head.kind == JOB_HDR_SINGLE)) &&
                       (step_reg < TAIL_START);
    assign tail_idx  = (head.kind == JOB_HDR_SINGLE) ? 2'(step_reg - TAIL_START)
                                                     : step_reg[1:0];
    assign is_pair   = (head.kind == JOB_PAIR);

    always_comb
    begin
        word_last = 1'b0;
        if (in_header)
        begin
            case (step_reg[2:0])
                3'd0:    word = {1'b0, ops.column_set};
                3'd1:    word = DATA_FLAG | {1'b0, head.x_lo};
                3'd2:    word = DATA_FLAG | {1'b0, head.x_hi};
                3'd3:    word = {1'b0, ops.page_set};
                3'd4:    word = DATA_FLAG | {1'b0, head.y_lo};
                3'd5:    word = DATA_FLAG | {1'b0, head.y_hi};
                default:
                begin
                    word      = {1'b0, ops.mem_write};
                    word_last = 1'b1;
                end
            endcase
        end
        else
        begin
            case (tail_idx)
                2'd0: word = DATA_FLAG | {1'b0, head.c1[11:4]};
                2'd1: word = DATA_FLAG |
                             {1'b0, head.c1[3:0], (is_pair ? head.c2[11:8] : 4'h0)};
                default:
                begin
                    // an unpaired pixel ends with a no-op command
                    word      = is_pair ? (DATA_FLAG | {1'b0, head.c2[7:0]})
                                        : {1'b0, ops.no_op};
                    word_last = 1'b1;
                end
            endcase
        end
    end

    assign load = head_valid && (!out_valid_reg || !out_stall);
    assign pop  = load && at_end;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
            step_next      = at_end ? 4'd0 : step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word;
            last_reg <= word_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign spi_word  = word_reg;
    assign last_word = last_reg;

    a_step_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (step_reg == 4'd0))
        else $error("word counter mid-job with empty queue");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (step_reg <= last_step))
        else $error("word counter past end of job");

endmodule

// ===== verif/lwwp_stream_checker.sv =====
// Request codes shared by the testbench files, and the stream checker that predicts
// the serial words of the LCD window write packer. Depends on lwwp_pkg from the design.
`timescale 1ns / 100ps

package lwwp_tb_pkg;

    typedef enum logic [2:0] {
        CMD_DRAW_PIXEL,
        CMD_OPEN_BLIT,
        CMD_BLIT_PIXEL,
        CMD_OPEN_FILL,
        CMD_FILL_STEP,
        CMD_SPARE_5,
        CMD_SPARE_6,
        CMD_SPARE_7
    } lcd_cmd_e;

endpackage

module lwwp_stream_checker
    import lwwp_pkg::*;
    import lwwp_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [7:0]  x_start,
    input  logic [7:0]  y_start,
    input  logic [7:0]  width_req,
    input  logic [7:0]  height_req,
    input  logic [11:0] color,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [8:0]  spi_word,
    input  logic        last_word,
    output int          fail_count,
    output int          words_pending,
    output int          words_checked
);

    localparam int MAX_REPORTS = 40;

    typedef enum logic [1:0] {
        WIN_IDLE,
        WIN_BLIT,
        WIN_FILL
    } win_mode_e;

    typedef struct packed {
        logic [8:0] word;
        logic       last;
    } spi_out_t;

    spi_out_t    owed_words [$];

    logic [7:0]  scr_w;
    logic [7:0]  scr_h;
    logic        check_bounds;
    logic [7:0]  op_col;
    logic [7:0]  op_page;
    logic [7:0]  op_write;
    logic [7:0]  op_nop;

    win_mode_e   win_mode;
    logic [15:0] units_owed;
    logic [11:0] held_color;
    logic        held_ok;
    logic [11:0] fill_rgb;

    task automatic note_failure(input string what, input int want, input int got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t checker: %s expected %03h got %03h", $time, what, want, got);
    endtask

    task automatic push_word(input logic [8:0] word, input logic last);
        owed_words.push_back('{word, last});
    endtask

    task automatic push_data(input logic [7:0] data_bits, input logic last);
        push_word(DATA_FLAG | {1'b0, data_bits}, last);
    endtask

    task automatic push_cmd(input logic [7:0] opcode, input logic last);
        push_word({1'b0, opcode}, last);
    endtask

    // end addresses wrap to 8 bits
    task automatic push_header(input logic [7:0] x, input logic [7:0] y,
                               input logic [7:0] w, input logic [7:0] h);
        push_cmd(op_col, 1'b0);
        push_data(x, 1'b0);
        push_data(8'(x + w - 8'd1), 1'b0);
        push_cmd(op_page, 1'b0);
        push_data(y, 1'b0);
        push_data(8'(y + h - 8'd1), 1'b0);
        push_cmd(op_write, 1'b1);
    endtask

    task automatic push_pair(input logic [11:0] c1, input logic [11:0] c2);
        push_data(c1[11:4], 1'b0);
        push_data({c1[3:0], c2[11:8]}, 1'b0);
        push_data(c2[7:0], 1'b1);
    endtask

    // a lone pixel is padded with a zero nibble and closed by a no-op
    task automatic push_lone_pixel(input logic [11:0] rgb);
        push_data(rgb[11:4], 1'b0);
        push_data({rgb[3:0], 4'h0}, 1'b0);
        push_cmd(op_nop, 1'b1);
    endtask

    task automatic abandon_window();
        win_mode   = WIN_IDLE;
        units_owed = '0;
        held_ok    = 1'b0;
        held_color = '0;
    endtask

    task automatic pack_request(input logic [2:0] op, input logic [7:0] x, input logic [7:0] y,
                                input logic [7:0] w, input logic [7:0] h,
                                input logic [11:0] rgb);
        logic        off_screen;
        int unsigned span_x;
        int unsigned span_y;
        off_screen = (x >= scr_w) || (y >= scr_h);
        span_x = w;
        span_y = h;
        case (lcd_cmd_e'(op))
            CMD_DRAW_PIXEL:
            begin
                if (check_bounds && off_screen)
                    return;
                abandon_window();
                push_header(x, y, 8'd1, 8'd1);
                push_lone_pixel(rgb);
            end
            CMD_OPEN_BLIT, CMD_OPEN_FILL:
            begin
                if (check_bounds)
                begin
                    if (w == 0 || h == 0 || off_screen)
                        return;
                    if (x + span_x > scr_w)
                    begin
                        if (lcd_cmd_e'(op) == CMD_OPEN_BLIT)
                            return;
                        span_x = scr_w - x;
                    end
                    if (y + span_y > scr_h)
                        span_y = scr_h - y;
                end
                abandon_window();
                if (lcd_cmd_e'(op) == CMD_OPEN_BLIT)
                begin
                    units_owed = 16'(span_x * span_y);
                    win_mode   = (units_owed != 0) ? WIN_BLIT : WIN_IDLE;
                end
                else
                begin
                    units_owed = 16'((span_x * span_y + 1) / 2);
                    fill_rgb   = rgb;
                    win_mode   = (units_owed != 0) ? WIN_FILL : WIN_IDLE;
                end
                push_header(x, y, span_x[7:0], span_y[7:0]);
            end
            CMD_BLIT_PIXEL:
            begin
                if (win_mode != WIN_BLIT || units_owed == 0)
                    return;
                units_owed = units_owed - 16'd1;
                if (held_ok)
                begin
                    push_pair(held_color, rgb);
                    held_ok    = 1'b0;
                    held_color = '0;
                end
                else if (units_owed == 0)
                    push_lone_pixel(rgb);
                else
                begin
                    // hold the first pixel of a pair
                    held_color = rgb;
                    held_ok    = 1'b1;
                end
                if (units_owed == 0)
                    abandon_window();
            end
            CMD_FILL_STEP:
            begin
                if (win_mode != WIN_FILL || units_owed == 0)
                    return;
                units_owed = units_owed - 16'd1;
                push_pair(fill_rgb, fill_rgb);
                if (units_owed == 0)
                    abandon_window();
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        spi_out_t want;
        if (!rst_n)
        begin
            scr_w         = RST_PANEL_WIDTH;
            scr_h         = RST_PANEL_HEIGHT;
            check_bounds  = 1'b1;
            op_col        = RST_OP_COLUMN_SET;
            op_page       = RST_OP_PAGE_SET;
            op_write      = RST_OP_MEM_WRITE;
            op_nop        = RST_OP_NO_OP;
            fill_rgb      = '0;
            abandon_window();
            owed_words.delete();
            fail_count    = 0;
            words_checked = 0;
            words_pending = 0;
        end
        else
        begin
            // a word cannot leave in the same cycle its request is taken
            if (out_valid && !out_stall)
            begin
                if (owed_words.size() == 0)
                    note_failure("unexpected spi_word", 0, spi_word);
                else
                begin
                    want = owed_words.pop_front();
                    words_checked++;
                    if (spi_word !== want.word)
                        note_failure("spi_word", want.word, spi_word);
                    if (last_word !== want.last)
                        note_failure("last_word", want.last, last_word);
                end
            end
            // a request taken at a register write still sees the old settings
            if (in_valid && !in_stall)
                pack_request(cmd, x_start, y_start, width_req, height_req, color);
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_PANEL_WIDTH:   scr_w        = cfg_wdata;
                    REG_PANEL_HEIGHT:  scr_h        = cfg_wdata;
                    REG_VALIDATE:      check_bounds = cfg_wdata[0];
                    REG_OP_COLUMN_SET: op_col       = cfg_wdata;
                    REG_OP_PAGE_SET:   op_page      = cfg_wdata;
                    REG_OP_MEM_WRITE:  op_write     = cfg_wdata;
                    REG_OP_NO_OP:      op_nop       = cfg_wdata;
                    default: ;
                endcase
            end
            words_pending = owed_words.size();
        end
    end

endmodule

// ===== verif/tb_lcd_window_write_packer.sv =====
// Testbench top for the LCD window write packer: clock, reset, register setup,
// request stimulus and output stalls. Depends on lwwp_pkg and lwwp_stream_checker.
`timescale 1ns / 100ps

module tb_lcd_window_write_packer;
    import lwwp_pkg::*;
    import lwwp_tb_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int LONG_HOLD      = 400;
    localparam int PHASE_REQUESTS = 85;
    localparam int RANDOM_PHASES  = 6;

    typedef struct packed {
        logic [7:0] width;
        logic [7:0] height;
        logic       check;
        logic [7:0] op_col;
        logic [7:0] op_page;
        logic [7:0] op_write;
        logic [7:0] op_nop;
    } panel_cfg_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  cmd;
    logic [7:0]  x_start;
    logic [7:0]  y_start;
    logic [7:0]  width_req;
    logic [7:0]  height_req;
    logic [11:0] color;
    logic        out_valid;
    logic        out_stall;
    logic [8:0]  spi_word;
    logic        last_word;

    int          fail_count;
    int          words_pending;
    int          words_checked;
    int          cycle_count   = 0;
    int          requests_sent = 0;
    int          burst_left    = 0;
    logic        long_hold_req = 1'b0;
    panel_cfg_t  live_cfg;

    lcd_window_write_packer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .x_start    (x_start),
        .y_start    (y_start),
        .width_req  (width_req),
        .height_req (height_req),
        .color      (color),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .spi_word   (spi_word),
        .last_word  (last_word)
    );

    lwwp_stream_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .x_start       (x_start),
        .y_start       (y_start),
        .width_req     (width_req),
        .height_req    (height_req),
        .color         (color),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .spi_word      (spi_word),
        .last_word     (last_word),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .words_checked (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // receiver: stall density changes in stretches, with one long hold-off on request
    initial
    begin : receiver
        int stretch_left;
        int stall_pct;
        int hold_left;
        logic hold_done;
        stretch_left = 0;
        stall_pct    = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_stall    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            stretch_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // entered and left at a falling edge; bursts of transfers with random gaps
    task automatic send_request(input lcd_cmd_e op, input logic [7:0] x, input logic [7:0] y,
                                input logic [7:0] w, input logic [7:0] h,
                                input logic [11:0] rgb);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        cmd        <= op;
        x_start    <= x;
        y_start    <= y;
        width_req  <= w;
        height_req <= h;
        color      <= rgb;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic program_registers(input panel_cfg_t s);
        logic [7:0] reg_value [8];
        reg_value[REG_PANEL_WIDTH]   = s.width;
        reg_value[REG_PANEL_HEIGHT]  = s.height;
        reg_value[REG_VALIDATE]      = {7'd0, s.check};
        reg_value[REG_OP_COLUMN_SET] = s.op_col;
        reg_value[REG_OP_PAGE_SET]   = s.op_page;
        reg_value[REG_OP_MEM_WRITE]  = s.op_write;
        reg_value[REG_OP_NO_OP]      = s.op_nop;
        for (int i = 0; i <= int'(REG_OP_NO_OP); i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= 3'(i);
            cfg_wdata <= reg_value[i];
            @(negedge clk);
        end
        cfg_we   <= 1'b0;
        live_cfg = s;
    endtask

    // drop valid, wait for every owed word, then let rejected requests drain
    task automatic settle();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (words_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic panel_cfg_t random_setting(input logic check);
        panel_cfg_t s;
        s.width    = 8'($urandom_range(1, 255));
        s.height   = 8'($urandom_range(1, 255));
        s.check    = check;
        s.op_col   = 8'($urandom);
        s.op_page  = 8'($urandom);
        s.op_write = 8'($urandom);
        s.op_nop   = 8'($urandom);
        return s;
    endfunction

    // mostly on screen, some at the far edge to force clipping, some anywhere
    function automatic logic [7:0] pick_coord(input logic [7:0] limit);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 8'($urandom_range(0, int'(limit) - 1));
        if (roll < 85)
            return 8'($urandom_range((limit > 4) ? int'(limit) - 4 : 0, int'(limit) - 1));
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 8'($urandom_range(1, 4));
        if (roll < 85)
            return 8'($urandom_range(0, 16));
        return 8'($urandom);
    endfunction

    task automatic random_phase(input int quota);
        int         first_sent;
        int         roll;
        int         area;
        int         steps;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] w;
        logic [7:0] h;
        first_sent = requests_sent;
        while (requests_sent - first_sent < quota)
        begin
            roll = $urandom_range(0, 99);
            x    = pick_coord(live_cfg.width);
            y    = pick_coord(live_cfg.height);
            w    = pick_size();
            h    = pick_size();
            area = int'(w) * int'(h);
            if (roll < 25)
                send_request(CMD_DRAW_PIXEL, x, y, 8'($urandom), 8'($urandom), 12'($urandom));
            else if (roll < 55)
            begin
                // stream the whole window when small, sometimes one pixel too many
                send_request(CMD_OPEN_BLIT, x, y, w, h, 12'($urandom));
                steps = (area <= 16) ? area + ($urandom_range(0, 4) == 0)
                                     : $urandom_range(1, 12);
                repeat (steps)
                    send_request(CMD_BLIT_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 12'($urandom));
            end
            else if (roll < 85)
            begin
                send_request(CMD_OPEN_FILL, x, y, w, h, 12'($urandom));
                steps = ((area + 1) / 2 <= 10) ? (area + 1) / 2 + ($urandom_range(0, 4) == 0)
                                               : $urandom_range(1, 10);
                repeat (steps)
                    send_request(CMD_FILL_STEP, 8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 12'($urandom));
            end
            else
                send_request(lcd_cmd_e'(3'($urandom_range(0, 7))), 8'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom), 12'($urandom));
        end
    endtask

    initial
    begin
        panel_cfg_t phase_cfg;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        cmd        = '0;
        x_start    = '0;
        y_start    = '0;
        width_req  = '0;
        height_req = '0;
        color      = '0;
        live_cfg   = '{RST_PANEL_WIDTH, RST_PANEL_HEIGHT, 1'b1, RST_OP_COLUMN_SET,
                       RST_OP_PAGE_SET, RST_OP_MEM_WRITE, RST_OP_NO_OP};
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed checks with the reset settings
        send_request(CMD_DRAW_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 12'hFFF);
        send_request(CMD_DRAW_PIXEL, 8'd131, 8'd131, 8'hFF, 8'hFF, 12'h000);
        send_request(CMD_DRAW_PIXEL, 8'd132, 8'd5, 8'd1, 8'd1, 12'h5A5);
        send_request(CMD_DRAW_PIXEL, 8'd5, 8'hFF, 8'd1, 8'd1, 12'hA5A);
        send_request(CMD_SPARE_5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'hFFF);
        send_request(CMD_SPARE_6, 8'd1, 8'd1, 8'd1, 8'd1, 12'h111);
        send_request(CMD_SPARE_7, 8'd0, 8'd0, 8'd2, 8'd2, 12'h000);
        send_request(CMD_BLIT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 12'h321);
        send_request(CMD_FILL_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 12'h654);
        send_request(CMD_OPEN_BLIT, 8'd0, 8'd0, 8'd3, 8'd1, 12'h000);
        send_request(CMD_BLIT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 12'h123);
        send_request(CMD_BLIT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 12'h456);
        send_request(CMD_BLIT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 12'h789);
        send_request(CMD_OPEN_BLIT, 8'd130, 8'd0, 8'd3, 8'd1, 12'h000);
        send_request(CMD_OPEN_FILL, 8'd10, 8'd10, 8'd0, 8'd4, 12'h000);
        send_request(CMD_OPEN_BLIT, 8'd10, 8'd130, 8'd2, 8'd5, 12'h000);
        send_request(CMD_BLIT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 12'hABC);
        send_request(CMD_DRAW_PIXEL, 8'd20, 8'd20, 8'd0, 8'd0, 12'hDEF);
        send_request(CMD_BLIT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 12'h0F0);
        send_request(CMD_OPEN_FILL, 8'd128, 8'd128, 8'hFF, 8'hFF, 12'hF0F);
        send_request(CMD_FILL_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 12'h000);
        send_request(CMD_FILL_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 12'hFFF);
        send_request(CMD_OPEN_FILL, 8'd131, 8'd131, 8'd1, 8'd1, 12'h0F0);
        send_request(CMD_FILL_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 12'h000);
        send_request(CMD_FILL_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 12'h000);
        settle();

        // unchecked: wrapped end address, zero area, oversize fill abandoned by a draw
        phase_cfg       = live_cfg;
        phase_cfg.check = 1'b0;
        program_registers(phase_cfg);
        send_request(CMD_OPEN_BLIT, 8'd250, 8'd250, 8'd10, 8'd0, 12'h000);
        send_request(CMD_BLIT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 12'h246);
        send_request(CMD_OPEN_FILL, 8'd200, 8'd0, 8'hFF, 8'hFF, 12'h9C3);
        send_request(CMD_FILL_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 12'h000);
        send_request(CMD_DRAW_PIXEL, 8'hFF, 8'hFF, 8'd0, 8'd0, 12'h8E1);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: phase_cfg = '{8'd255, 8'd255, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
                1: phase_cfg = '{8'd1, 8'd1, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00};
                2: phase_cfg = '{RST_PANEL_WIDTH, RST_PANEL_HEIGHT, 1'b0, 8'($urandom),
                                 8'($urandom), 8'($urandom), 8'($urandom)};
                3: phase_cfg = random_setting(1'b1);
                4: phase_cfg = random_setting(1'b0);
                default: phase_cfg = random_setting(1'($urandom));
            endcase
            program_registers(phase_cfg);
            if (p == 0)
                long_hold_req = 1'b1;
            random_phase(PHASE_REQUESTS);
            settle();
        end

        $display("Covered %0d requests and %0d serial words over %0d register settings,",
                 requests_sent, words_checked, RANDOM_PHASES + 2);
        $display("with clipped, rejected, stray, odd-length and abandoned windows.");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== lcd_window_write_packer.f =====
design/lwwp_pkg.sv
design/lwwp_front.sv
design/lwwp_queue.sv
design/lwwp_back.sv
design/lcd_window_write_packer.sv
verif/lwwp_stream_checker.sv
verif/tb_lcd_window_write_packer.sv
